/* hw/rtl/jsu_pkg.sv */
`default_nettype none

package jsu_pkg;

  // Depth of the queue between the parser and the encoder.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_SYNTAX  = 2'd1;
  localparam logic [1:0] ERR_UNICODE = 2'd2;

  // What the parser asks the encoder to produce for one input byte.
  typedef enum logic [2:0] {
    OP_EMPTY = 3'd0,
    OP_RAW   = 3'd1,
    OP_CP    = 3'd2,
    OP_DONE  = 3'd3,
    OP_ESYN  = 3'd4,
    OP_EUNI  = 3'd5
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [20:0] val;
  } cmd_t;

  // Handshake between the queue and the encoder.
  typedef struct packed {
    logic valid;
    cmd_t head;
  } qhead_t;

endpackage

`default_nettype wire

/* hw/rtl/jsu_front.sv */
`default_nettype none

module jsu_front (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         take,
  input  wire logic [7:0]   data_byte,
  input  wire logic         end_of_input,
  output jsu_pkg::cmd_t     cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_TEXT  = 7'b0000010,
    S_ESC   = 7'b0000100,
    S_HEX1  = 7'b0001000,
    S_LOWBS = 7'b0010000,
    S_LOWU  = 7'b0100000,
    S_HEX2  = 7'b1000000
  } mode_t;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [5:0] HI_TAG   = 6'b110110;
  localparam logic [5:0] LO_TAG   = 6'b110111;

  mode_t        mode, mode_next;
  logic [1:0]   hex_cnt, hex_cnt_next;
  logic [15:0]  accum, accum_next;
  logic [9:0]   hs, hs_next;
  logic         nib_ok;
  logic [3:0]   nib;
  logic [15:0]  unit;
  logic [10:0]  plane;

  always_comb begin
    nib_ok = 1'b1;
    nib    = 4'd0;
    if (data_byte >= 8'h30 && data_byte <= 8'h39) begin
      nib = data_byte[3:0];
    end else if ((data_byte >= 8'h61 && data_byte <= 8'h66) ||
                 (data_byte >= 8'h41 && data_byte <= 8'h46)) begin
      nib = data_byte[3:0] + 4'd9;
    end else begin
      nib_ok = 1'b0;
    end
  end

  assign unit  = {accum[11:0], nib};
  // The high surrogate selects the plane; adding 0x40 at bit 10 adds 0x10000.
  assign plane = {1'b0, hs} + 11'h040;

  always_comb begin
    mode_next    = mode;
    hex_cnt_next = hex_cnt;
    accum_next   = accum;
    hs_next      = hs;
    cmd.op       = jsu_pkg::OP_EMPTY;
    cmd.val      = 21'd0;
    if (end_of_input) begin
      mode_next = S_IDLE;
      cmd.op    = (mode == S_LOWBS || mode == S_LOWU) ? jsu_pkg::OP_EUNI
                                                      : jsu_pkg::OP_ESYN;
    end else begin
      unique case (mode)
        S_TEXT: begin
          if (data_byte == CH_QUOTE) begin
            cmd.op    = jsu_pkg::OP_DONE;
            mode_next = S_IDLE;
          end else if (data_byte < 8'h20) begin
            cmd.op    = jsu_pkg::OP_ESYN;
            mode_next = S_IDLE;
          end else if (data_byte == CH_BSL) begin
            mode_next = S_ESC;
          end else begin
            cmd.op  = jsu_pkg::OP_RAW;
            cmd.val = {13'd0, data_byte};
          end
        end
        S_ESC: begin
          mode_next = S_TEXT;
          cmd.op    = jsu_pkg::OP_RAW;
          case (data_byte)
            8'h22, 8'h5c, 8'h2f: cmd.val = {13'd0, data_byte};
            8'h62: cmd.val = 21'h08;
            8'h66: cmd.val = 21'h0c;
            8'h6e: cmd.val = 21'h0a;
            8'h72: cmd.val = 21'h0d;
            8'h74: cmd.val = 21'h09;
            CH_U: begin
              cmd.op       = jsu_pkg::OP_EMPTY;
              mode_next    = S_HEX1;
              hex_cnt_next = 2'd0;
              accum_next   = 16'd0;
            end
            default: begin
              cmd.op    = jsu_pkg::OP_ESYN;
              mode_next = S_IDLE;
            end
          endcase
        end
        S_HEX1, S_HEX2: begin
          if (!nib_ok) begin
            cmd.op    = jsu_pkg::OP_ESYN;
            mode_next = S_IDLE;
          end else if (hex_cnt != 2'd3) begin
            accum_next   = unit;
            hex_cnt_next = hex_cnt + 2'd1;
          end else begin
            accum_next   = unit;
            hex_cnt_next = 2'd0;
            if (mode == S_HEX1) begin
              if (unit[15:10] == LO_TAG) begin
                cmd.op    = jsu_pkg::OP_EUNI;
                mode_next = S_IDLE;
              end else if (unit[15:10] == HI_TAG) begin
                hs_next   = unit[9:0];
                mode_next = S_LOWBS;
              end else begin
                cmd.op    = jsu_pkg::OP_CP;
                cmd.val   = {5'd0, unit};
                mode_next = S_TEXT;
              end
            end else begin
              if (unit[15:10] != LO_TAG) begin
                cmd.op    = jsu_pkg::OP_EUNI;
                mode_next = S_IDLE;
              end else begin
                cmd.op    = jsu_pkg::OP_CP;
                cmd.val   = {plane, unit[9:0]};
                mode_next = S_TEXT;
              end
            end
          end
        end
        S_LOWBS: begin
          if (data_byte != CH_BSL) begin
            cmd.op    = jsu_pkg::OP_EUNI;
            mode_next = S_IDLE;
          end else begin
            mode_next = S_LOWU;
          end
        end
        S_LOWU: begin
          if (data_byte != CH_U) begin
            cmd.op    = jsu_pkg::OP_EUNI;
            mode_next = S_IDLE;
          end else begin
            mode_next    = S_HEX2;
            hex_cnt_next = 2'd0;
            accum_next   = 16'd0;
          end
        end
        default: begin
          if (data_byte != CH_QUOTE) begin
            cmd.op    = jsu_pkg::OP_ESYN;
            mode_next = S_IDLE;
          end else begin
            mode_next = S_TEXT;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= S_IDLE;
      hex_cnt <= 2'd0;
    end else if (take) begin
      mode    <= mode_next;
      hex_cnt <= hex_cnt_next;
    end
    if (take) begin
      accum <= accum_next;
      hs    <= hs_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/jsu_queue.sv */
`default_nettype none

module jsu_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr,
  input  wire jsu_pkg::cmd_t  wr_cmd,
  output logic                q_full,
  input  wire logic           rd,
  output jsu_pkg::qhead_t     q_out
);

  jsu_pkg::cmd_t               mem [jsu_pkg::QDEPTH];
  logic [jsu_pkg::QAW-1:0]     wptr, rptr;
  logic [jsu_pkg::QAW:0]       cnt;

  assign q_full      = (cnt == (jsu_pkg::QAW+1)'(jsu_pkg::QDEPTH));
  assign q_out.valid = (cnt != '0);
  assign q_out.head  = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + 1'b1;
      end
      if (rd) begin
        rptr <= rptr + 1'b1;
      end
      if (wr && !rd) begin
        cnt <= cnt + 1'b1;
      end else if (rd && !wr) begin
        cnt <= cnt - 1'b1;
      end
    end
    if (wr) begin
      mem[wptr] <= wr_cmd;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/jsu_back.sv */
`default_nettype none

module jsu_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire jsu_pkg::qhead_t  q_in,
  output logic                  q_rd,
  output logic                  empty,
  input  wire logic             pop,
  output logic [31:0]           out_data,
  output logic [2:0]            out_count,
  output logic                  string_done,
  output logic [1:0]            error_code
);

  logic        out_valid;
  logic [31:0] enc_data;
  logic [2:0]  enc_count;
  logic        enc_done;
  logic [1:0]  enc_err;
  logic [20:0] cp;

  assign cp    = q_in.head.val;
  assign empty = !out_valid;
  assign q_rd  = q_in.valid && (!out_valid || pop);

  always_comb begin
    enc_data  = 32'd0;
    enc_count = 3'd0;
    enc_done  = 1'b0;
    enc_err   = jsu_pkg::ERR_NONE;
    unique case (q_in.head.op)
      jsu_pkg::OP_RAW: begin
        enc_data  = {24'd0, cp[7:0]};
        enc_count = 3'd1;
      end
      jsu_pkg::OP_CP: begin
        if (cp < 21'h80) begin
          enc_data  = {24'd0, 1'b0, cp[6:0]};
          enc_count = 3'd1;
        end else if (cp < 21'h800) begin
          enc_data  = {16'd0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
          enc_count = 3'd2;
        end else if (cp < 21'h10000) begin
          enc_data  = {8'd0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
          enc_count = 3'd3;
        end else begin
          enc_data  = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12],
                       5'b11110, cp[20:18]};
          enc_count = 3'd4;
        end
      end
      jsu_pkg::OP_DONE: enc_done = 1'b1;
      jsu_pkg::OP_ESYN: enc_err  = jsu_pkg::ERR_SYNTAX;
      jsu_pkg::OP_EUNI: enc_err  = jsu_pkg::ERR_UNICODE;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_rd) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
    if (q_rd) begin
      out_data    <= enc_data;
      out_count   <= enc_count;
      string_done <= enc_done;
      error_code  <= enc_err;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/json_string_unescape.sv */
`default_nettype none

// Decodes a JSON string one raw byte per beat, starting at its opening quote,
// and answers every byte with exactly one result beat: up to four decoded
// bytes packed low byte first with a count, string_done on the closing quote,
// or an error code (1 syntax, 2 bad unicode escape), after which the decoder
// is idle and waits for the next opening quote. A \u escape comes out as
// UTF-8, with surrogate pairs joined into one four-byte character; the bytes
// of an escape before its last digit give empty beats. One byte is taken
// every clock cycle while full is low, with no gaps between strings; a result
// passes from the parser, which writes the four-entry command queue at the
// edge that takes its byte, to the UTF-8 encoder, which loads the output
// register once that register is empty or being popped. Back-pressure on pop
// fills the queue and then raises full.
module json_string_unescape (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte,
  input  wire logic        end_of_input,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      out_data,
  output logic [2:0]       out_count,
  output logic             string_done,
  output logic [1:0]       error_code
);

  logic             take;
  logic             q_rd;
  jsu_pkg::cmd_t    cmd;
  jsu_pkg::qhead_t  qh;

  assign take = push && !full;

  jsu_front u_front (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .data_byte    (data_byte),
    .end_of_input (end_of_input),
    .cmd          (cmd)
  );

  jsu_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (take),
    .wr_cmd (cmd),
    .q_full (full),
    .rd     (q_rd),
    .q_out  (qh)
  );

  jsu_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_in        (qh),
    .q_rd        (q_rd),
    .empty       (empty),
    .pop         (pop),
    .out_data    (out_data),
    .out_count   (out_count),
    .string_done (string_done),
    .error_code  (error_code)
  );

  // A waiting command always reaches an idle output register in the next cycle.
  a_drain: assert property (@(posedge clk) disable iff (rst)
    qh.valid && empty |=> !empty)
    else $error("queued command did not reach the output register");

  // A done or error beat carries no decoded bytes.
  a_no_data_on_status: assert property (@(posedge clk) disable iff (rst)
    !empty && (string_done || error_code != jsu_pkg::ERR_NONE) |->
      out_count == 3'd0 && out_data == 32'd0)
    else $error("status beat carries data");

  // Never more than four bytes, and done never comes with an error.
  a_beat_sane: assert property (@(posedge clk) disable iff (rst)
    !empty |-> out_count <= 3'd4 && !(string_done && error_code != jsu_pkg::ERR_NONE))
    else $error("malformed result beat");

  // The queue only reports full when it holds commands for the encoder.
  a_full_has_data: assert property (@(posedge clk) disable iff (rst)
    full |-> qh.valid && !empty)
    else $error("full without pending results");

endmodule

`default_nettype wire
